FILE: rtl/ntfs_pkg.sv
// Shared constants for the nearest-track-first scheduler.
// No dependencies; imported by the top level.
`default_nettype none

package ntfs_pkg;

  // Request store size and track width
  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_BITS   = 16;

  // Field widths of the stream items
  localparam int TRACK_FIELD_W = 16;
  localparam int POS_W         = 16;
  localparam int SEEK_W        = 22;
  localparam int OUT_DATA_W    = 40;

  // Derived sizes
  localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int DIST_W = TRACK_BITS + 1;
  localparam int ADD_W  = ((TRACK_BITS > SEEK_W) ? TRACK_BITS : SEEK_W) + 1;

  localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

endpackage : ntfs_pkg

`default_nettype wire

FILE: rtl/nearest_track_first_scheduler_unit.sv
// Nearest-track-first (shortest seek first) track scheduler, top level.
// Depends on ntfs_pkg for sizes and widths.
`default_nettype none

// Usage
//   Write the start track on cfg_we_i/cfg_wdata_i while the block is idle.
//   Stream track requests on the slave side, one item per request; tlast
//   marks the final request of a batch and starts scheduling. Up to
//   MAX_REQUESTS requests are kept, later ones are dropped and flagged.
//   The master side then emits the start position followed by one item per
//   stored request in service order. The final item carries tlast, the
//   total seek distance in tdata and the overflow flag in tuser.
// Timing
//   A loading item is taken whenever tvalid and tready are high. After the last
//   item of a batch of N requests, each pick runs one shared distance/compare
//   unit over the N stored entries through the single read port of the
//   request store: N reads, a compare of each registered read, then one emit.
//   tready stays low from the last item of a batch until its final result
//   sits in the output register.
// Reset and stall
//   Reset clears the batch state, the head and the start track. A stalled
//   receiver holds the output item; the sequencer waits before each emit.
module nearest_track_first_scheduler_unit
  import ntfs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration: start_position
  input  wire logic                     cfg_we_i,
  input  wire logic [POS_W-1:0]         cfg_wdata_i,
  // request stream
  input  wire logic                     s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire logic [TRACK_FIELD_W-1:0] s_axis_tdata_i,   // [15:0] track
  input  wire logic                     s_axis_tlast_i,   // last
  // schedule stream
  output logic                          m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]         m_axis_tdata_o,   // [15:0] position,
                                                          // [37:16] seek total, pad
  output logic                          m_axis_tlast_o,   // final_res
  output logic                          m_axis_tuser_o    // overflow
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_STEP
  } state_e;

  state_e                  state_q, state_d;
  logic [POS_W-1:0]        start_q, start_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [MAX_REQUESTS-1:0] served_q, served_d;
  logic [TRACK_BITS-1:0]   head_q, head_d;
  logic [SEEK_W-1:0]       seek_q, seek_d;
  logic                    dropped_q, dropped_d;
  logic [CNT_W-1:0]        pick_q, pick_d;
  logic [CNT_W-1:0]        scan_q, scan_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]        cmp_idx_q, cmp_idx_d;
  logic [DIST_W-1:0]       best_dist_q, best_dist_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [TRACK_BITS-1:0]   best_trk_q, best_trk_d;
  logic                    out_vld_q, out_vld_d;
  logic [POS_W-1:0]        out_pos_q, out_pos_d;
  logic [SEEK_W-1:0]       out_seek_q, out_seek_d;
  logic                    out_last_q, out_last_d;
  logic                    out_user_q, out_user_d;

  // request store, one write and one registered read port
  logic [TRACK_BITS-1:0]   mem_q [MAX_REQUESTS];
  logic [TRACK_BITS-1:0]   rd_q;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [TRACK_BITS-1:0]   wr_data;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;

  logic                    in_acc;
  logic                    out_free;
  logic [TRACK_BITS-1:0]   head_gap;
  logic [ADD_W-1:0]        sum_wide;
  logic [SEEK_W-1:0]       sum_sat;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;

  // shared distance unit: current store entry against the head
  assign head_gap = (rd_q > head_q) ? (rd_q - head_q) : (head_q - rd_q);

  // saturating seek accumulate of the picked distance
  assign sum_wide = ADD_W'(seek_q) + ADD_W'(best_dist_q[TRACK_BITS-1:0]);
  assign sum_sat  = (sum_wide > ADD_W'(SEEK_MAX)) ? SEEK_MAX : sum_wide[SEEK_W-1:0];

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    count_d     = count_q;
    served_d    = served_q;
    head_d      = head_q;
    seek_d      = seek_q;
    dropped_d   = dropped_q;
    pick_d      = pick_q;
    scan_d      = scan_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    best_trk_d  = best_trk_q;
    out_vld_d   = out_vld_q;
    out_pos_d   = out_pos_q;
    out_seek_d  = out_seek_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[IDX_W-1:0];
    wr_data     = TRACK_BITS'(s_axis_tdata_i);
    rd_en       = 1'b0;
    rd_addr     = scan_q[IDX_W-1:0];

    if (cfg_we_i) begin
      start_d = cfg_wdata_i;
    end

    // drop the output item once taken
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_q < CNT_W'(MAX_REQUESTS)) begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            head_d  = TRACK_BITS'(start_q);
            seek_d  = '0;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_pos_d  = POS_W'(head_q);
          out_seek_d = '0;
          if (count_q == '0) begin
            out_last_d = 1'b1;
            out_user_d = dropped_q;
            served_d   = '0;
            count_d    = '0;
            seek_d     = '0;
            dropped_d  = 1'b0;
            state_d    = ST_LOAD;
          end else begin
            out_last_d  = 1'b0;
            out_user_d  = 1'b0;
            pick_d      = '0;
            scan_d      = '0;
            cmp_vld_d   = 1'b0;
            best_dist_d = '1;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue the next read
        cmp_vld_d = 1'b0;
        if (scan_q != count_q) begin
          rd_en     = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[IDX_W-1:0];
          scan_d    = scan_q + 1'b1;
        end
        // compare the entry read last cycle; strict less keeps the earliest
        if (cmp_vld_q && !served_q[cmp_idx_q] && ({1'b0, head_gap} < best_dist_q)) begin
          best_dist_d = {1'b0, head_gap};
          best_idx_d  = cmp_idx_q;
          best_trk_d  = rd_q;
        end
        if ((scan_q == count_q) && !cmp_vld_q) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (out_free) begin
          served_d[best_idx_q] = 1'b1;
          seek_d    = sum_sat;
          head_d    = best_trk_q;
          out_vld_d = 1'b1;
          out_pos_d = POS_W'(best_trk_q);
          if (pick_q == (count_q - 1'b1)) begin
            out_seek_d = sum_sat;
            out_last_d = 1'b1;
            out_user_d = dropped_q;
            served_d   = '0;
            count_d    = '0;
            seek_d     = '0;
            dropped_d  = 1'b0;
            state_d    = ST_LOAD;
          end else begin
            out_seek_d  = '0;
            out_last_d  = 1'b0;
            out_user_d  = 1'b0;
            pick_d      = pick_q + 1'b1;
            scan_d      = '0;
            best_dist_d = '1;
            state_d     = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      start_q     <= '0;
      count_q     <= '0;
      served_q    <= '0;
      head_q      <= '0;
      seek_q      <= '0;
      dropped_q   <= 1'b0;
      pick_q      <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      best_dist_q <= '1;
      best_idx_q  <= '0;
      best_trk_q  <= '0;
      out_vld_q   <= 1'b0;
      out_pos_q   <= '0;
      out_seek_q  <= '0;
      out_last_q  <= 1'b0;
      out_user_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      count_q     <= count_d;
      served_q    <= served_d;
      head_q      <= head_d;
      seek_q      <= seek_d;
      dropped_q   <= dropped_d;
      pick_q      <= pick_d;
      scan_q      <= scan_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      best_dist_q <= best_dist_d;
      best_idx_q  <= best_idx_d;
      best_trk_q  <= best_trk_d;
      out_vld_q   <= out_vld_d;
      out_pos_q   <= out_pos_d;
      out_seek_q  <= out_seek_d;
      out_last_q  <= out_last_d;
      out_user_q  <= out_user_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - SEEK_W - POS_W)'(0), out_seek_q, out_pos_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

  // the fill count never passes the store size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_REQUESTS))
    else $error("request count exceeds store size");

  // a pick about to be emitted exists and was never served before
  a_pick_unserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (!served_q[best_idx_q] && (best_dist_q != '1)))
    else $error("emitted pick is served or missing");

  // overflow only shows on the final item
  a_ovf_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("overflow flag on non-final item");

  // seek total is zero on every non-final item
  a_seek_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (out_seek_q == '0))
    else $error("seek total on non-final item");

  // no input is taken while a schedule is running
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("ready while scheduling");

endmodule : nearest_track_first_scheduler_unit

`default_nettype wire
